### design/mi3_pkg.sv
// shared types and constants of the 3x3 matrix inverse unit
package mi3_pkg;

	localparam int FIELD_WIDTH    = 32;
	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int NUM_ELEMS      = 9;

	typedef enum logic {
		OP_INVERSE       = 1'b0,
		OP_INV_TRANSPOSE = 1'b1
	} opcode_t;

	typedef logic signed [FIELD_WIDTH-1:0] field_t;

endpackage

### design/mi3_in_if.sv
// input channel: opcode and nine matrix elements
interface mi3_in_if;
	import mi3_pkg::*;

	logic valid;
	logic ready;
	opcode_t opcode;
	field_t a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source (
		output valid, opcode, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready
	);
	modport sink (
		input valid, opcode, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready
	);
endinterface

### design/mi3_out_if.sv
// output channel: nine result elements and status flags
interface mi3_out_if;
	import mi3_pkg::*;

	logic valid;
	logic ready;
	field_t b00, b01, b02, b10, b11, b12, b20, b21, b22;
	logic singular;
	logic saturated;

	modport source (
		output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22, singular, saturated,
		input ready
	);
	modport sink (
		input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22, singular, saturated,
		output ready
	);
endinterface

### design/mi3_cofactor.sv
// cofactor stages: 2x2 minor products, then differences
module mi3_cofactor #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic [1:0]               en,
	input  mi3_pkg::field_t          elem_in [mi3_pkg::NUM_ELEMS],
	input  mi3_pkg::opcode_t         opcode_in,
	output logic signed [2*ELEM_WIDTH:0] cof_s2 [mi3_pkg::NUM_ELEMS],
	output logic signed [ELEM_WIDTH-1:0] row0_s2 [3],
	output mi3_pkg::opcode_t         opcode_s2
);
	import mi3_pkg::*;

	localparam int W  = ELEM_WIDTH;
	localparam int PW = 2 * W;
	localparam int CW = 2 * W + 1;

	logic signed [W-1:0]  m [NUM_ELEMS];
	logic signed [PW-1:0] pa_s1 [NUM_ELEMS];
	logic signed [PW-1:0] pb_s1 [NUM_ELEMS];
	logic signed [W-1:0]  row0_s1 [3];
	opcode_t              opcode_s1;

	genvar g;
	generate
		for (g = 0; g < NUM_ELEMS; g++) begin : g_cof
			localparam int R  = g / 3;
			localparam int C  = g % 3;
			localparam int R1 = (R + 1) % 3;
			localparam int R2 = (R + 2) % 3;
			localparam int C1 = (C + 1) % 3;
			localparam int C2 = (C + 2) % 3;

			// only the low element bits count
			assign m[g] = elem_in[g][W-1:0];

			always_ff @(posedge clk) begin
				if (en[0]) begin
					pa_s1[g] <= m[R1*3+C1] * m[R2*3+C2];
					pb_s1[g] <= m[R1*3+C2] * m[R2*3+C1];
				end
				if (en[1]) begin
					cof_s2[g] <= CW'(pa_s1[g]) - CW'(pb_s1[g]);
				end
			end
		end

		for (g = 0; g < 3; g++) begin : g_row0
			always_ff @(posedge clk) begin
				if (en[0]) begin
					row0_s1[g] <= m[g];
				end
				if (en[1]) begin
					row0_s2[g] <= row0_s1[g];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en[0]) begin
			opcode_s1 <= opcode_in;
		end
		if (en[1]) begin
			opcode_s2 <= opcode_s1;
		end
	end

endmodule

### design/mi3_determinant.sv
// determinant stages: split partial products, then signed sum
module mi3_determinant #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic [1:0]                   en,
	input  logic signed [2*ELEM_WIDTH:0] cof_s2 [mi3_pkg::NUM_ELEMS],
	input  logic signed [ELEM_WIDTH-1:0] row0_s2 [3],
	input  mi3_pkg::opcode_t             opcode_s2,
	output logic signed [2*ELEM_WIDTH:0] cof_s4 [mi3_pkg::NUM_ELEMS],
	output logic signed [3*ELEM_WIDTH+1:0] det_s4,
	output mi3_pkg::opcode_t             opcode_s4
);
	import mi3_pkg::*;

	localparam int W  = ELEM_WIDTH;
	localparam int CW = 2 * W + 1;
	localparam int MW = 2 * W;
	localparam int TW = 3 * W;
	localparam int DW = 3 * W + 2;

	logic [W-1:0]  araw [3];
	logic [W-1:0]  amag [3];
	logic [CW-1:0] craw [3];
	logic [MW-1:0] cmag [3];

	logic [2*W-1:0] pl_s3 [3];
	logic [2*W-1:0] ph_s3 [3];
	logic [2:0]     neg_s3;
	logic signed [CW-1:0] cof_s3 [NUM_ELEMS];
	opcode_t        opcode_s3;

	logic [TW-1:0]        term [3];
	logic signed [DW-1:0] sterm [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			araw[j] = row0_s2[j];
			amag[j] = araw[j][W-1] ? -araw[j] : araw[j];
			craw[j] = cof_s2[j];
			cmag[j] = MW'(craw[j][CW-1] ? -craw[j] : craw[j]);
			term[j] = (TW'(ph_s3[j]) << W) + TW'(pl_s3[j]);
			sterm[j] = neg_s3[j] ? -DW'(term[j]) : DW'(term[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < 3; j++) begin
				pl_s3[j]  <= amag[j] * cmag[j][W-1:0];
				ph_s3[j]  <= amag[j] * cmag[j][MW-1:W];
				neg_s3[j] <= araw[j][W-1] ^ craw[j][CW-1];
			end
			cof_s3    <= cof_s2;
			opcode_s3 <= opcode_s2;
		end
		if (en[1]) begin
			det_s4    <= sterm[0] + sterm[1] + sterm[2];
			cof_s4    <= cof_s3;
			opcode_s4 <= opcode_s3;
		end
	end

endmodule

### design/mi3_div_step.sv
// one restoring division stage: decides one quotient bit for all nine elements
module mi3_div_step #(
	parameter int QUOT_WIDTH = 33,
	parameter int DET_WIDTH  = 98,
	parameter int REM_WIDTH  = 131,
	parameter int BIT_POS    = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DET_WIDTH-1:0]  dmag_in,
	input  logic [REM_WIDTH-1:0]  rem_in [mi3_pkg::NUM_ELEMS],
	input  logic [QUOT_WIDTH-1:0] q_in [mi3_pkg::NUM_ELEMS],
	input  logic [mi3_pkg::NUM_ELEMS-1:0] neg_in,
	input  logic [mi3_pkg::NUM_ELEMS-1:0] ovf_in,
	input  logic                  sing_in,
	output logic [DET_WIDTH-1:0]  dmag_s1,
	output logic [REM_WIDTH-1:0]  rem_s1 [mi3_pkg::NUM_ELEMS],
	output logic [QUOT_WIDTH-1:0] q_s1 [mi3_pkg::NUM_ELEMS],
	output logic [mi3_pkg::NUM_ELEMS-1:0] neg_s1,
	output logic [mi3_pkg::NUM_ELEMS-1:0] ovf_s1,
	output logic                  sing_s1
);
	import mi3_pkg::*;

	logic [REM_WIDTH-1:0]  dsh;
	logic [REM_WIDTH-1:0]  rem_nxt [NUM_ELEMS];
	logic [QUOT_WIDTH-1:0] q_nxt [NUM_ELEMS];

	always_comb begin
		dsh = REM_WIDTH'(dmag_in) << BIT_POS;
		for (int g = 0; g < NUM_ELEMS; g++) begin
			q_nxt[g] = q_in[g];
			if (rem_in[g] >= dsh) begin
				rem_nxt[g] = rem_in[g] - dsh;
				q_nxt[g][BIT_POS] = 1'b1;
			end else begin
				rem_nxt[g] = rem_in[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s1 <= dmag_in;
			rem_s1  <= rem_nxt;
			q_s1    <= q_nxt;
			neg_s1  <= neg_in;
			ovf_s1  <= ovf_in;
			sing_s1 <= sing_in;
		end
	end

endmodule

### design/mi3_divider.sv
// scaling stages: magnitudes, overflow check, bit-per-stage division, saturation
module mi3_divider #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic [ELEM_WIDTH+3:0]          en,
	input  logic signed [2*ELEM_WIDTH:0]   cof_s4 [mi3_pkg::NUM_ELEMS],
	input  logic signed [3*ELEM_WIDTH+1:0] det_s4,
	input  mi3_pkg::opcode_t               opcode_s4,
	output mi3_pkg::field_t                res_q [mi3_pkg::NUM_ELEMS],
	output logic                           singular_q,
	output logic                           saturated_q
);
	import mi3_pkg::*;

	localparam int W  = ELEM_WIDTH;
	localparam int CW = 2 * W + 1;
	localparam int MW = 2 * W;
	localparam int DW = 3 * W + 2;
	localparam int NW = 2 * W + 2 * FRAC_BITS;
	localparam int RW = (NW > DW + W + 1) ? NW : DW + W + 1;
	localparam int QW = W + 1;
	localparam int NSTEP = W + 1;

	logic [DW-1:0] draw;
	logic [CW-1:0] csel [NUM_ELEMS];
	logic [MW-1:0] cmag [NUM_ELEMS];

	logic [DW-1:0]        dmag_s5;
	logic [NW-1:0]        nmag_s5 [NUM_ELEMS];
	logic [NUM_ELEMS-1:0] neg_s5;
	logic                 sing_s5;

	logic [DW-1:0]        dmag_ch [NSTEP+1];
	logic [RW-1:0]        rem_ch [NSTEP+1][NUM_ELEMS];
	logic [QW-1:0]        q_ch [NSTEP+1][NUM_ELEMS];
	logic [NUM_ELEMS-1:0] neg_ch [NSTEP+1];
	logic [NUM_ELEMS-1:0] ovf_ch [NSTEP+1];
	logic                 sing_ch [NSTEP+1];

	logic [QW-1:0]        limit [NUM_ELEMS];
	logic [QW-1:0]        qmag [NUM_ELEMS];
	logic [W-1:0]         val [NUM_ELEMS];
	logic [NUM_ELEMS-1:0] over;

	assign draw = det_s4;

	genvar g;
	generate
		for (g = 0; g < NUM_ELEMS; g++) begin : g_sel
			localparam int TI = (g % 3) * 3 + g / 3;
			// inverse takes the adjugate, i.e. the transposed cofactor matrix
			assign csel[g] = (opcode_s4 == OP_INV_TRANSPOSE) ? cof_s4[g] : cof_s4[TI];
			assign cmag[g] = MW'(csel[g][CW-1] ? -csel[g] : csel[g]);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dmag_s5 <= draw[DW-1] ? -draw : draw;
			sing_s5 <= (draw == '0);
			for (int k = 0; k < NUM_ELEMS; k++) begin
				nmag_s5[k] <= NW'(cmag[k]) << (2 * FRAC_BITS);
				neg_s5[k]  <= csel[k][CW-1] ^ draw[DW-1];
			end
		end
		if (en[1]) begin
			dmag_ch[0] <= dmag_s5;
			sing_ch[0] <= sing_s5;
			neg_ch[0]  <= neg_s5;
			for (int k = 0; k < NUM_ELEMS; k++) begin
				// quotient would need more bits than the step chain produces
				ovf_ch[0][k] <= RW'(nmag_s5[k]) >= (RW'(dmag_s5) << (W + 1));
				rem_ch[0][k] <= RW'(nmag_s5[k]);
				q_ch[0][k]   <= '0;
			end
		end
	end

	genvar t;
	generate
		for (t = 0; t < NSTEP; t++) begin : g_step
			mi3_div_step #(
				.QUOT_WIDTH (QW),
				.DET_WIDTH  (DW),
				.REM_WIDTH  (RW),
				.BIT_POS    (W - t)
			) u_step (
				.clk     (clk),
				.en      (en[2+t]),
				.dmag_in (dmag_ch[t]),
				.rem_in  (rem_ch[t]),
				.q_in    (q_ch[t]),
				.neg_in  (neg_ch[t]),
				.ovf_in  (ovf_ch[t]),
				.sing_in (sing_ch[t]),
				.dmag_s1 (dmag_ch[t+1]),
				.rem_s1  (rem_ch[t+1]),
				.q_s1    (q_ch[t+1]),
				.neg_s1  (neg_ch[t+1]),
				.ovf_s1  (ovf_ch[t+1]),
				.sing_s1 (sing_ch[t+1])
			);
		end
	endgenerate

	always_comb begin
		for (int k = 0; k < NUM_ELEMS; k++) begin
			limit[k] = neg_ch[NSTEP][k] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - 1'b1);
			over[k]  = ovf_ch[NSTEP][k] || (q_ch[NSTEP][k] > limit[k]);
			qmag[k]  = over[k] ? limit[k] : q_ch[NSTEP][k];
			val[k]   = neg_ch[NSTEP][k] ? -qmag[k][W-1:0] : qmag[k][W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[W+3]) begin
			singular_q  <= sing_ch[NSTEP];
			saturated_q <= !sing_ch[NSTEP] && (|over);
			for (int k = 0; k < NUM_ELEMS; k++) begin
				res_q[k] <= sing_ch[NSTEP] ? '0 : FIELD_WIDTH'(signed'(val[k]));
			end
		end
	end

endmodule

### design/matrix_inverse_3x3_unit.sv
// top level of the 3x3 matrix inverse unit
// 3x3 matrix inverse by adjugate, signed fixed point (Q16.16 by default).
// channels: mat takes one transaction per matrix (opcode plus nine elements
// a00..a22, row-major); inv delivers one transaction per matrix with the
// nine result elements b00..b22 and the singular and saturated flags.
// opcode OP_INVERSE gives the inverse, OP_INV_TRANSPOSE its transpose.
// pipeline from accept to inv.valid: two cofactor stages, two determinant
// stages, two divider setup stages, one stage per quotient bit
// (ELEM_WIDTH + 1) and the output register.
// throughput: one matrix per cycle while inv takes results; the quotient
// chain is fully pipelined with nine subtract-compare lanes in every stage.
// each stage carries a valid bit and moves when the next stage is empty or
// moving, so bubbles collapse and new matrices keep entering while a result
// waits on inv; mat.ready drops only when every stage holds a matrix.
// a stalled result holds its value until taken; nothing is lost or repeated.
// reset (arst_n low) clears the valid bits only, not the datapath registers.
// singular matrix: all results zero, singular high, saturated low.
module matrix_inverse_3x3_unit #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mi3_in_if.sink    mat,
	mi3_out_if.source inv
);
	import mi3_pkg::*;

	// total pipeline depth including the output register
	localparam int NS = ELEM_WIDTH + 8;

	logic [NS-1:0] vld_q;
	logic [NS:0]   en;

	field_t  elem [NUM_ELEMS];
	field_t  res [NUM_ELEMS];
	logic    singular_q;
	logic    saturated_q;

	logic signed [2*ELEM_WIDTH:0]   cof_s2 [NUM_ELEMS];
	logic signed [ELEM_WIDTH-1:0]   row0_s2 [3];
	opcode_t                        opcode_s2;
	logic signed [2*ELEM_WIDTH:0]   cof_s4 [NUM_ELEMS];
	logic signed [3*ELEM_WIDTH+1:0] det_s4;
	opcode_t                        opcode_s4;

	// stage moves when empty or when the stage after it moves
	assign en[NS] = inv.ready;
	genvar s;
	generate
		for (s = 0; s < NS; s++) begin : g_en
			assign en[s] = !vld_q[s] || en[s+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= mat.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign mat.ready = en[0];
	assign inv.valid = vld_q[NS-1];

	assign elem[0] = mat.a00;
	assign elem[1] = mat.a01;
	assign elem[2] = mat.a02;
	assign elem[3] = mat.a10;
	assign elem[4] = mat.a11;
	assign elem[5] = mat.a12;
	assign elem[6] = mat.a20;
	assign elem[7] = mat.a21;
	assign elem[8] = mat.a22;

	// minors of the 2x2 submatrices
	mi3_cofactor #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_cofactor (
		.clk       (clk),
		.en        (en[1:0]),
		.elem_in   (elem),
		.opcode_in (mat.opcode),
		.cof_s2    (cof_s2),
		.row0_s2   (row0_s2),
		.opcode_s2 (opcode_s2)
	);

	// expansion along row 0
	mi3_determinant #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_determinant (
		.clk       (clk),
		.en        (en[3:2]),
		.cof_s2    (cof_s2),
		.row0_s2   (row0_s2),
		.opcode_s2 (opcode_s2),
		.cof_s4    (cof_s4),
		.det_s4    (det_s4),
		.opcode_s4 (opcode_s4)
	);

	// adjugate scaled by the reciprocal determinant, truncated and clipped
	mi3_divider #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_divider (
		.clk         (clk),
		.en          (en[NS-1:4]),
		.cof_s4      (cof_s4),
		.det_s4      (det_s4),
		.opcode_s4   (opcode_s4),
		.res_q       (res),
		.singular_q  (singular_q),
		.saturated_q (saturated_q)
	);

	assign inv.b00       = res[0];
	assign inv.b01       = res[1];
	assign inv.b02       = res[2];
	assign inv.b10       = res[3];
	assign inv.b11       = res[4];
	assign inv.b12       = res[5];
	assign inv.b20       = res[6];
	assign inv.b21       = res[7];
	assign inv.b22       = res[8];
	assign inv.singular  = singular_q;
	assign inv.saturated = saturated_q;

endmodule

### design/mi3_checker.sv
// port-level checks of the matrix inverse unit and their binding
module mi3_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input mi3_pkg::field_t out_b00,
	input mi3_pkg::field_t out_b11,
	input mi3_pkg::field_t out_b22,
	input logic            out_singular,
	input logic            out_saturated
);
	import mi3_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps b00 and its flags
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_b00) && $stable(out_singular)
			&& $stable(out_saturated))
		else $error("result changed while stalled");

	// a receiver that takes results never blocks the input
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready || !out_valid |-> in_ready)
		else $error("input blocked although the pipeline can move");

	// singular results have zero b00, b11 and b22 and are never saturated
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_singular |-> !out_saturated && out_b00 == '0
			&& out_b11 == '0 && out_b22 == '0)
		else $error("singular result not cleared");

	// no result right after reset releases
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present out of reset");

endmodule

bind matrix_inverse_3x3_unit mi3_checker u_mi3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (mat.ready),
	.out_valid     (inv.valid),
	.out_ready     (inv.ready),
	.out_b00       (inv.b00),
	.out_b11       (inv.b11),
	.out_b22       (inv.b22),
	.out_singular  (inv.singular),
	.out_saturated (inv.saturated)
);

### dv/tb_matrix_inverse_3x3_unit.sv
// testbench for the 3x3 matrix inverse unit: directed and random matrices against a predictor
module tb_matrix_inverse_3x3_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import mi3_pkg::*;

	localparam int PIPE_LATENCY = 40;

	// one expected result of the block
	typedef struct {
		field_t b[9];
		logic   singular;
		logic   saturated;
	} inv_result_t;

	typedef logic signed [127:0] wide_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mi3_in_if  mat_ch();
	mi3_out_if inv_ch();

	matrix_inverse_3x3_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat_ch),
		.inv    (inv_ch)
	);

	always #1 clk = ~clk;

	// expected results, oldest first
	inv_result_t expected_inverses[$];
	int unsigned mismatch_count = 0;
	int unsigned burst_left = 0;

	// exact cofactor / determinant inverse, truncated toward zero and clipped to Q16.16
	function automatic inv_result_t predict_inverse(opcode_t op, field_t a[9]);
		inv_result_t res;
		wide_t m[3][3];
		wide_t cof[3][3];
		wide_t det;
		wide_t num;
		logic [127:0] n_mag, d_mag, quo, limit;
		logic neg;
		res.singular = 1'b0;
		res.saturated = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = wide_t'(a[i*3+j]);
		// cofactor (i,j) with the cyclic index trick, sign comes out right by itself
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
					- m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
		det = m[0][0]*cof[0][0] + m[0][1]*cof[0][1] + m[0][2]*cof[0][2];
		if (det == 0) begin
			foreach (res.b[k]) res.b[k] = '0;
			res.singular = 1'b1;
			return res;
		end
		d_mag = (det < 0) ? -det : det;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				// inverse uses the adjugate, i.e. the transposed cofactor matrix
				num = (op == OP_INV_TRANSPOSE) ? cof[i][j] : cof[j][i];
				neg = (num < 0) != (det < 0);
				n_mag = ((num < 0) ? -num : num) << 32;  // two fraction scalings
				quo = n_mag / d_mag;
				limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
				if (quo > limit) begin
					quo = limit;
					res.saturated = 1'b1;
				end
				res.b[i*3+j] = neg ? field_t'(-quo[31:0]) : field_t'(quo[31:0]);
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// sends one matrix; gaps come between random-length bursts
	task automatic send_matrix(opcode_t op, field_t a[9]);
		if (burst_left == 0) begin
			int unsigned gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				mat_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		mat_ch.valid  <= 1'b1;
		mat_ch.opcode <= op;
		mat_ch.a00 <= a[0]; mat_ch.a01 <= a[1]; mat_ch.a02 <= a[2];
		mat_ch.a10 <= a[3]; mat_ch.a11 <= a[4]; mat_ch.a12 <= a[5];
		mat_ch.a20 <= a[6]; mat_ch.a21 <= a[7]; mat_ch.a22 <= a[8];
		do @(posedge clk); while (!mat_ch.ready);
		expected_inverses.push_back(predict_inverse(op, a));
	endtask

	// hold the sender off until every outstanding result has come back
	task automatic wait_for_drain();
		mat_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_inverses.size() != 0) @(posedge clk);
	endtask

	function automatic field_t rand_field();
		case ($urandom_range(0, 5))
			0: return field_t'($urandom);
			1: return field_t'($signed($urandom_range(0, 131072)) - 65536);  // about +-1.0
			2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			3: return field_t'($signed($urandom_range(0, 16)) - 8);           // tiny
			default: return field_t'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
		endcase
	endfunction

	task automatic test_identity_and_scaled();
		field_t a[9];
		a = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
		send_matrix(OP_INVERSE, a);
		send_matrix(OP_INV_TRANSPOSE, a);
		// diagonal 2.0, -4.0, 0.5 with an upper triangle so transpose differs
		a = '{32'sh20000, 32'sh18000, -32'sh7000, 0, -32'sh40000, 32'sh3, 0, 0, 32'sh8000};
		send_matrix(OP_INVERSE, a);
		send_matrix(OP_INV_TRANSPOSE, a);
		// negative determinant through a row swap
		a = '{0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0, 32'sh30000};
		send_matrix(OP_INVERSE, a);
	endtask

	task automatic test_singular();
		field_t a[9];
		a = '{default: 0};
		send_matrix(OP_INVERSE, a);
		// two equal rows
		a = '{32'sh1234, -32'sh55, 32'sh7fff_ffff, 32'sh1234, -32'sh55, 32'sh7fff_ffff, 1, 2, 3};
		send_matrix(OP_INV_TRANSPOSE, a);
		// column proportional to another
		a = '{1, 2, 5, 3, 6, 7, -4, -8, 9};
		send_matrix(OP_INVERSE, a);
	endtask

	task automatic test_extremes_and_saturation();
		field_t a[9];
		// smallest nonzero diagonal: inverse far out of range
		a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(OP_INVERSE, a);
		a = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};
		send_matrix(OP_INV_TRANSPOSE, a);
		a = '{default: 32'sh8000_0000};
		a[4] = 32'sh7fff_ffff;
		send_matrix(OP_INVERSE, a);
		a = '{32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
		send_matrix(OP_INVERSE, a);
		a = '{32'sh7fff_ffff, 32'sh8000_0000, 1, -1, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000, 1, 32'sh7fff_ffff};
		send_matrix(OP_INV_TRANSPOSE, a);
		a = '{32'sh7fff_ffff, -1, -1, -1, -1, -1, -1, -1, 32'sh7fff_ffff};
		send_matrix(OP_INVERSE, a);
		// inverse exactly -32768.0: the negative limit without clipping
		a = '{-32'sh2, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
		send_matrix(OP_INVERSE, a);
		for (int k = 0; k < 6; k++) begin
			foreach (a[e]) a[e] = field_t'($urandom);
			send_matrix(opcode_t'(k[0]), a);
		end
	endtask

	task automatic test_random_matrices(int unsigned count);
		field_t a[9];
		for (int unsigned n = 0; n < count; n++) begin
			foreach (a[e]) a[e] = rand_field();
			case ($urandom_range(0, 9))
				0: begin  // duplicate a row to force a singular matrix
					int unsigned r;
					r = $urandom_range(0, 2);
					for (int c = 0; c < 3; c++) a[((r+1)%3)*3+c] = a[r*3+c];
				end
				1, 2, 3: begin  // well conditioned: dominant diagonal
					foreach (a[e]) a[e] = field_t'($signed($urandom_range(0, 32'h1_0000)) - 32'sh8000);
					for (int d = 0; d < 3; d++)
						a[d*4] = field_t'($signed($urandom_range(32'h2_0000, 32'h40_0000)))
							* ($urandom_range(0, 1) ? 1 : -1);
				end
				default: ;
			endcase
			send_matrix(opcode_t'($urandom_range(0, 1)), a);
			if (n == count / 2) wait_for_drain();
		end
	endtask

	// receiver stall pattern: runs of always-ready, random, and sparse ready
	always @(posedge clk or negedge arst_n) begin
		int unsigned stall_mode;
		int unsigned stall_phase;
		if (!arst_n) begin
			inv_ch.ready <= 1'b0;
		end else begin
			stall_phase = $urandom_range(0, 63);
			if (stall_phase == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: inv_ch.ready <= 1'b1;
				1: inv_ch.ready <= ($urandom_range(0, 9) < 7);
				default: inv_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// result checker: every inv transaction is compared with the oldest prediction
	always @(posedge clk) begin
		inv_result_t want;
		field_t got[9];
		if (arst_n && inv_ch.valid && inv_ch.ready) begin
			got = '{inv_ch.b00, inv_ch.b01, inv_ch.b02, inv_ch.b10, inv_ch.b11, inv_ch.b12,
				inv_ch.b20, inv_ch.b21, inv_ch.b22};
			if (expected_inverses.size() == 0) begin
				$display("unexpected inv transaction at %0t", $realtime);
				mismatch_count++;
			end else begin
				want = expected_inverses.pop_front();
				foreach (got[k])
					if (got[k] !== want.b[k])
						report_mismatch($sformatf("b%0d%0d", k / 3, k % 3), got[k], want.b[k]);
				if (inv_ch.singular !== want.singular)
					report_mismatch("singular", 32'(inv_ch.singular), 32'(want.singular));
				if (inv_ch.saturated !== want.saturated)
					report_mismatch("saturated", 32'(inv_ch.saturated), 32'(want.saturated));
			end
		end
	end

	initial begin
		mat_ch.valid = 1'b0;
		mat_ch.opcode = OP_INVERSE;
		{mat_ch.a00, mat_ch.a01, mat_ch.a02} = '0;
		{mat_ch.a10, mat_ch.a11, mat_ch.a12} = '0;
		{mat_ch.a20, mat_ch.a21, mat_ch.a22} = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_and_scaled();
		test_singular();
		test_extremes_and_saturation();
		wait_for_drain();
		test_random_matrices(880);
		mat_ch.valid <= 1'b0;
		while (expected_inverses.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 20) @(posedge clk);
		if (mismatch_count == 0 && expected_inverses.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
design/mi3_pkg.sv
design/mi3_in_if.sv
design/mi3_out_if.sv
design/mi3_cofactor.sv
design/mi3_determinant.sv
design/mi3_div_step.sv
design/mi3_divider.sv
design/matrix_inverse_3x3_unit.sv
design/mi3_checker.sv
dv/tb_matrix_inverse_3x3_unit.sv
